// ----- hw/rtl/tci_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package tci_pkg;

	// Cipher geometry: each round is split over two half-round cells.
	localparam int ROUNDS = 32;
	localparam int CELLS  = 2 * ROUNDS;

	localparam logic [31:0] DELTA   = 32'h9e3779b9;
	// Starting sum for decryption: delta times the round count, modulo 2^32.
	localparam logic [31:0] DEC_SUM = 32'(64'(DELTA) * 64'(ROUNDS));

	// Command codes.
	localparam logic [1:0] CMD_ENC     = 2'd0;
	localparam logic [1:0] CMD_DEC     = 2'd1;
	localparam logic [1:0] CMD_NEXT_ID = 2'd2;
	localparam logic [1:0] CMD_RESTART = 2'd3;

	// Configuration register indexes.
	localparam logic [1:0] REG_KEY0 = 2'd0;
	localparam logic [1:0] REG_KEY1 = 2'd1;
	localparam logic [1:0] REG_KEY2 = 2'd2;
	localparam logic [1:0] REG_KEY3 = 2'd3;

	// The 128-bit key as four words.
	typedef struct packed {
		logic [31:0] k0;
		logic [31:0] k1;
		logic [31:0] k2;
		logic [31:0] k3;
	} key_t;

	// A block in flight through the chain of round cells.
	typedef struct packed {
		logic [31:0] v0;
		logic [31:0] v1;
		logic [31:0] sum;
		logic        enc;
		logic        load;
	} blk_t;

endpackage

`default_nettype wire

// ----- hw/rtl/tci_req_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface tci_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  cmd;
	logic [31:0] word0_in;
	logic [31:0] word1_in;

	modport source (output valid, output cmd, output word0_in, output word1_in, input ready);
	modport sink (input valid, input cmd, input word0_in, input word1_in, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/tci_rsp_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface tci_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] word0_out;
	logic [31:0] word1_out;

	modport source (output valid, output word0_out, output word1_out, input ready);
	modport sink (input valid, input word0_out, input word1_out, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/tci_key_regs.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tci_key_regs (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_we,
	input  wire logic [1:0]   cfg_index,
	input  wire logic [31:0]  cfg_data,
	output tci_pkg::key_t     key
);
	import tci_pkg::*;

	key_t key_q;

	// Key words are written one at a time through the plain write port.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_KEY0: key_q.k0 <= cfg_data;
				REG_KEY1: key_q.k1 <= cfg_data;
				REG_KEY2: key_q.k2 <= cfg_data;
				REG_KEY3: key_q.k3 <= cfg_data;
				default: key_q <= key_q;
			endcase
		end
	end

	assign key = key_q;

endmodule

`default_nettype wire

// ----- hw/rtl/tci_round_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tci_round_cell (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire logic          phase_b,
	input  wire tci_pkg::key_t key,
	input  wire logic          valid_in,
	input  wire tci_pkg::blk_t d_in,
	output logic               valid_out,
	output tci_pkg::blk_t      d_out
);
	import tci_pkg::*;

	logic        upd0;
	logic [31:0] x;
	logic [31:0] ka;
	logic [31:0] kb;
	logic [31:0] mix;
	logic [31:0] v;
	logic [31:0] v_new;
	logic [31:0] sum_next;
	blk_t        d_next;
	logic        valid_q;
	blk_t        d_q;

	// One half round. Encryption updates word 0 first, decryption word 1 first,
	// so the word to update follows from the mode and the cell's phase.
	always_comb begin
		upd0     = d_in.enc ^ phase_b;
		x        = upd0 ? d_in.v1 : d_in.v0;
		ka       = upd0 ? key.k0 : key.k2;
		kb       = upd0 ? key.k1 : key.k3;
		v        = upd0 ? d_in.v0 : d_in.v1;
		mix      = ((x << 4) + ka) ^ (x + d_in.sum) ^ ((x >> 5) + kb);
		v_new    = d_in.enc ? (v + mix) : (v - mix);
		// The sum is kept ready for the next round at the end of each round.
		sum_next = phase_b ? (d_in.enc ? (d_in.sum + DELTA) : (d_in.sum - DELTA))
		                   : d_in.sum;
		d_next      = d_in;
		d_next.sum  = sum_next;
		if (upd0) begin
			d_next.v0 = v_new;
		end else begin
			d_next.v1 = v_new;
		end
	end

	// Valid bit is control state; the block word needs no reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_q <= d_next;
		end
	end

	assign valid_out = valid_q;
	assign d_out     = d_q;

endmodule

`default_nettype wire

// ----- hw/rtl/tea_counter_id_generator.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  Handshake      Word
// req      in   valid/ready    cmd, word0_in, word1_in
// rsp      out  valid/ready    word0_out, word1_out
// cfg      in   cfg_we         cfg_index, cfg_data (key words 0..3)
//
// A word passes through a chain of 64 half-round cells and then an output register
// that drives rsp.valid; one request per cycle unless rsp stalls or a restart is pending.
// A restart-counter command blocks new requests until its result
// has left the last cell, because the counter is loaded from that result.
// A stalled response freezes the whole chain. Reset clears valid bits,
// the counter and the key; there is no clearing pass.

module tea_counter_id_generator (
	input  wire logic        clk,
	input  wire logic        arst_n,
	tci_req_if.sink          req,
	tci_rsp_if.source        rsp,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);
	import tci_pkg::*;

	key_t        key;
	logic        advance;
	logic        accept;
	logic        pending_q;
	logic [63:0] counter_q;
	logic [63:0] counter_inc;
	blk_t        entry;
	logic        cell_valid [CELLS+1];
	blk_t        cell_data [CELLS+1];
	logic        out_valid_q;
	logic [31:0] out_word0_q;
	logic [31:0] out_word1_q;
	logic        last_valid;
	blk_t        last_data;

	tci_key_regs u_key_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.key       (key)
	);

	// The chain moves whenever the output register is free or being drained.
	assign advance     = !out_valid_q || rsp.ready;
	assign req.ready   = advance && !pending_q;
	assign accept      = req.valid && req.ready;
	assign counter_inc = counter_q + 64'd1;

	// Build the word that enters the first cell.
	always_comb begin
		entry.v0   = req.word0_in;
		entry.v1   = req.word1_in;
		entry.enc  = 1'b1;
		entry.load = 1'b0;
		case (req.cmd)
			CMD_ENC: begin
				entry.enc = 1'b1;
			end
			CMD_DEC: begin
				entry.enc = 1'b0;
			end
			CMD_NEXT_ID: begin
				entry.v0  = counter_inc[31:0];
				entry.v1  = counter_inc[63:32];
				entry.enc = 1'b1;
			end
			default: begin
				entry.v0   = '0;
				entry.v1   = '0;
				entry.enc  = 1'b0;
				entry.load = 1'b1;
			end
		endcase
		entry.sum = entry.enc ? DELTA : DEC_SUM;
	end

	assign cell_valid[0] = accept;
	assign cell_data[0]  = entry;

	// The row of half-round cells; odd cells close a round.
	for (genvar i = 0; i < CELLS; i++) begin : g_cell
		tci_round_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (advance),
			.phase_b   ((i % 2) == 1),
			.key       (key),
			.valid_in  (cell_valid[i]),
			.d_in      (cell_data[i]),
			.valid_out (cell_valid[i+1]),
			.d_out     (cell_data[i+1])
		);
	end

	assign last_valid = cell_valid[CELLS];
	assign last_data  = cell_data[CELLS];

	// Identifier counter: bumped on each accepted next-id request, reloaded when
	// a restart word leaves the chain. Requests wait while a reload is outstanding.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			counter_q <= '0;
			pending_q <= 1'b0;
		end else begin
			if (advance && last_valid && last_data.load) begin
				counter_q <= {last_data.v1, last_data.v0};
				pending_q <= 1'b0;
			end else if (accept && req.cmd == CMD_RESTART) begin
				pending_q <= 1'b1;
			end else if (accept && req.cmd == CMD_NEXT_ID) begin
				counter_q <= counter_inc;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= last_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_word0_q <= last_data.v0;
			out_word1_q <= last_data.v1;
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.word0_out = out_word0_q;
	assign rsp.word1_out = out_word1_q;

endmodule

`default_nettype wire
